### hdl/ssm_pkg.sv
package ssm_pkg;

    localparam int ID_W = 64;

    localparam logic [1:0] FUNC_LOAD_CUR = 2'd0;
    localparam logic [1:0] FUNC_LOAD_ADD = 2'd1;
    localparam logic [1:0] FUNC_LOAD_REM = 2'd2;
    localparam logic [1:0] FUNC_RUN      = 2'd3;

    typedef struct packed {
        logic load;
        logic start;
        logic eval;
    } t_ssm_cmd;

    typedef struct packed {
        logic advance;
        logic done;
    } t_ssm_status;

endpackage

### hdl/sorted_set_merge_remove.sv
// channel | valid      | stall       | payload
// input   | i_in_valid | o_in_stall  | i_func, i_id_value
// output  | o_out_valid| i_out_stall | o_member, o_last, o_empty_res, o_overflow
//
// Loads may follow every cycle while no run holds the input stalled.
// A run walks one step per add id, per current id without an equal add head, and per
// remove id skipped below a current id; each step reads the list RAMs in a read state
// and is evaluated once the registered read data of the list RAMs is available.
// Reset (synchronous) clears the list counts and overflow flag; RAM contents are not cleared.
// A full, held output register pauses emits behind a held candidate and the run end; input is stalled during a run.
module sorted_set_merge_remove
    import ssm_pkg::*;
#(
    parameter int SET_CAPACITY = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [1:0]      i_func,
    input  logic [ID_W-1:0] i_id_value,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [ID_W-1:0] o_member,
    output logic            o_last,
    output logic            o_empty_res,
    output logic            o_overflow
);

    t_ssm_cmd    cmd;
    t_ssm_status status;

    ssm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ssm_datapath #(.SET_CAPACITY(SET_CAPACITY)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_func),
        .i_id_value  (i_id_value),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_member    (o_member),
        .o_last      (o_last),
        .o_empty_res (o_empty_res),
        .o_overflow  (o_overflow)
    );

endmodule

### hdl/ssm_ram.sv
module ssm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ssm_ctrl.sv
module ssm_ctrl
    import ssm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [1:0]  i_func,
    input  t_ssm_status i_status,
    output t_ssm_cmd    o_cmd,
    output logic        o_in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   accept;

    assign accept = i_in_valid && !r_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_func == FUNC_RUN) begin
                        r_state    <= S_READ;
                        r_in_stall <= 1'b1;
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (i_status.done) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end else if (i_status.advance) begin
                        r_state <= S_READ;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_stall <= 1'b0;
                end
            endcase
        end
    end

    assign o_cmd.load  = accept && i_func != FUNC_RUN;
    assign o_cmd.start = accept && i_func == FUNC_RUN;
    assign o_cmd.eval  = r_state == S_EVAL;
    assign o_in_stall  = r_in_stall;

    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_stall == (r_state != S_IDLE))
        else $error("input stall disagrees with controller state");

    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL |-> $past(r_state) == S_READ || $past(r_state) == S_EVAL)
        else $error("evaluation entered without a read cycle");

    a_done_only_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.done |-> r_state == S_EVAL)
        else $error("run completed outside evaluation");

endmodule

### hdl/ssm_datapath.sv
module ssm_datapath
    import ssm_pkg::*;
#(
    parameter int SET_CAPACITY = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ssm_cmd         i_cmd,
    input  logic [1:0]       i_func,
    input  logic [ID_W-1:0]  i_id_value,
    output t_ssm_status      o_status,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [ID_W-1:0]  o_member,
    output logic             o_last,
    output logic             o_empty_res,
    output logic             o_overflow
);

    localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

    logic [CW-1:0]   r_cur_cnt, r_add_cnt, r_rem_cnt;
    logic [CW-1:0]   r_ic, r_ia, r_id;
    logic            r_ovf;
    logic            r_cand_valid;
    logic [ID_W-1:0] r_cand;
    logic            r_out_valid;
    logic [ID_W-1:0] r_out_member;
    logic            r_out_last, r_out_empty, r_out_ovf;

    logic [ID_W-1:0] cur_rd, add_rd, rem_rd;
    logic            nonzero;
    logic            we_cur, we_add, we_rem;
    logic            full_sel;

    logic            hc, ha, hr;
    logic            emit, fin;
    logic [ID_W-1:0] emit_val;
    logic            inc_c, inc_a, inc_r;
    logic            out_free, can_emit;
    logic            step_fire, emit_fire, done_fire, cand_push;

    assign nonzero = i_id_value != '0;

    always_comb begin
        case (i_func)
            FUNC_LOAD_CUR: full_sel = r_cur_cnt == CAP;
            FUNC_LOAD_ADD: full_sel = r_add_cnt == CAP;
            default:       full_sel = r_rem_cnt == CAP;
        endcase
    end

    assign we_cur = i_cmd.load && nonzero && !full_sel && i_func == FUNC_LOAD_CUR;
    assign we_add = i_cmd.load && nonzero && !full_sel && i_func == FUNC_LOAD_ADD;
    assign we_rem = i_cmd.load && nonzero && !full_sel && i_func == FUNC_LOAD_REM;

    ssm_ram #(.WIDTH(ID_W), .DEPTH(SET_CAPACITY)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (we_cur),
        .i_waddr (r_cur_cnt[AW-1:0]),
        .i_wdata (i_id_value),
        .i_raddr (r_ic[AW-1:0]),
        .o_rdata (cur_rd)
    );

    ssm_ram #(.WIDTH(ID_W), .DEPTH(SET_CAPACITY)) u_add_ram (
        .i_clk   (i_clk),
        .i_we    (we_add),
        .i_waddr (r_add_cnt[AW-1:0]),
        .i_wdata (i_id_value),
        .i_raddr (r_ia[AW-1:0]),
        .o_rdata (add_rd)
    );

    ssm_ram #(.WIDTH(ID_W), .DEPTH(SET_CAPACITY)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (we_rem),
        .i_waddr (r_rem_cnt[AW-1:0]),
        .i_wdata (i_id_value),
        .i_raddr (r_id[AW-1:0]),
        .o_rdata (rem_rd)
    );

    assign hc = r_ic < r_cur_cnt;
    assign ha = r_ia < r_add_cnt;
    assign hr = r_id < r_rem_cnt;

    always_comb begin
        emit     = 1'b0;
        fin      = 1'b0;
        emit_val = add_rd;
        inc_c    = 1'b0;
        inc_a    = 1'b0;
        inc_r    = 1'b0;
        if (ha && (!hc || add_rd < cur_rd)) begin
            emit  = 1'b1;
            inc_a = 1'b1;
        end else if (hc && (!ha || cur_rd < add_rd)) begin
            if (hr && rem_rd < cur_rd) begin
                inc_r = 1'b1;
            end else if (hr && rem_rd == cur_rd) begin
                inc_r = 1'b1;
                inc_c = 1'b1;
            end else begin
                emit     = 1'b1;
                emit_val = cur_rd;
                inc_c    = 1'b1;
            end
        end else if (hc && ha) begin
            emit  = 1'b1;
            inc_a = 1'b1;
            inc_c = 1'b1;
        end else begin
            fin = 1'b1;
        end
    end

    // candidate is held back one emission so that the final one can be marked
    assign out_free  = !r_out_valid || !i_out_stall;
    assign can_emit  = !r_cand_valid || out_free;
    assign emit_fire = i_cmd.eval && emit && can_emit;
    assign step_fire = i_cmd.eval && !fin && (!emit || can_emit);
    assign done_fire = i_cmd.eval && fin && out_free;
    assign cand_push = emit_fire && r_cand_valid;

    assign o_status.advance = step_fire;
    assign o_status.done    = done_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_cnt    <= '0;
            r_add_cnt    <= '0;
            r_rem_cnt    <= '0;
            r_ovf        <= 1'b0;
            r_cand_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ic         <= '0;
            r_ia         <= '0;
            r_id         <= '0;
        end else begin
            if (i_cmd.load && nonzero && full_sel) begin
                r_ovf <= 1'b1;
            end
            if (we_cur) begin
                r_cur_cnt <= r_cur_cnt + CW'(1);
            end
            if (we_add) begin
                r_add_cnt <= r_add_cnt + CW'(1);
            end
            if (we_rem) begin
                r_rem_cnt <= r_rem_cnt + CW'(1);
            end
            if (i_cmd.start) begin
                r_ic <= '0;
                r_ia <= '0;
                r_id <= '0;
            end else if (step_fire) begin
                if (inc_c) begin
                    r_ic <= r_ic + CW'(1);
                end
                if (inc_a) begin
                    r_ia <= r_ia + CW'(1);
                end
                if (inc_r) begin
                    r_id <= r_id + CW'(1);
                end
            end
            if (emit_fire) begin
                r_cand_valid <= 1'b1;
            end
            if (done_fire) begin
                r_cand_valid <= 1'b0;
                r_cur_cnt    <= '0;
                r_add_cnt    <= '0;
                r_rem_cnt    <= '0;
                r_ovf        <= 1'b0;
            end
            if (cand_push || done_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_cand <= emit_val;
        end
        if (cand_push) begin
            r_out_member <= r_cand;
            r_out_last   <= 1'b0;
            r_out_empty  <= 1'b0;
            r_out_ovf    <= r_ovf;
        end else if (done_fire) begin
            r_out_member <= r_cand_valid ? r_cand : '0;
            r_out_last   <= 1'b1;
            r_out_empty  <= !r_cand_valid;
            r_out_ovf    <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_member    = r_out_member;
    assign o_last      = r_out_last;
    assign o_empty_res = r_out_empty;
    assign o_overflow  = r_out_ovf;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_cnt <= CAP && r_add_cnt <= CAP && r_rem_cnt <= CAP)
        else $error("list count beyond capacity");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> r_ic <= r_cur_cnt && r_ia <= r_add_cnt && r_id <= r_rem_cnt)
        else $error("walk index beyond list count");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_fire |=> r_cur_cnt == '0 && r_add_cnt == '0 && r_rem_cnt == '0
                      && !r_ovf && !r_cand_valid)
        else $error("run end did not clear the lists");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_empty |-> r_out_last && r_out_member == '0)
        else $error("malformed empty result");

endmodule
